// ===== design/rbsi_pkg.sv =====
package rbsi_pkg;

  // default geometry of the coordinates
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam int unsigned NUM_AXES = 3;

  // register map, one slot per register
  typedef enum logic [2:0] {
    REG_LOW_X  = 3'd0,
    REG_LOW_Y  = 3'd1,
    REG_LOW_Z  = 3'd2,
    REG_HIGH_X = 3'd3,
    REG_HIGH_Y = 3'd4,
    REG_HIGH_Z = 3'd5,
    REG_SPARE0 = 3'd6,
    REG_SPARE1 = 3'd7
  } box_reg_e;

endpackage

// ===== design/ray_in_if.sv =====
interface ray_in_if #(
  parameter int unsigned W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] origin_x;
  logic signed [W-1:0] origin_y;
  logic signed [W-1:0] origin_z;
  logic signed [W-1:0] heading_x;
  logic signed [W-1:0] heading_y;
  logic signed [W-1:0] heading_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, heading_x, heading_y, heading_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, heading_x, heading_y, heading_z,
    output ready
  );
endinterface

// ===== design/hit_out_if.sv =====
interface hit_out_if #(
  parameter int unsigned W = 32
);
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [W-1:0] entry_distance;

  modport source (
    output valid, hit, entry_distance,
    input  ready
  );
  modport sink (
    input  valid, hit, entry_distance,
    output ready
  );
endinterface

// ===== design/rbsi_div.sv =====
module rbsi_div #(
  parameter int unsigned COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH:0]   num_i,
  input  logic signed [COORD_WIDTH-1:0] den_i,
  output logic signed [COORD_WIDTH-1:0] quo_o
);
  import rbsi_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned NW = CW + 1 + FRAC_BITS;

  localparam logic [NW-1:0] CAP  = NW'(1) << (CW - 1);
  localparam logic [NW-1:0] MAXQ = CAP - NW'(1);
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // stage registers: x holds dividend bits going out and quotient bits coming in
  logic [NW-1:0] x_q   [NW+1];
  logic [CW-1:0] r_q   [NW+1];
  logic [CW-1:0] dm_q  [NW+1];
  logic          neg_q [NW+1];
  logic          sp_q  [NW+1];
  logic [CW-1:0] spv_q [NW+1];
  logic [CW-1:0] quo_q;

  logic [CW:0]   nmag;
  logic [CW-1:0] dmag;
  logic          nneg;
  logic          dneg;
  logic          spec;
  logic [CW-1:0] specv;

  // magnitudes, signs and the saturating special cases
  always_comb begin
    nneg = num_i[CW];
    dneg = den_i[CW-1];
    nmag = nneg ? (~num_i + (CW+1)'(1)) : num_i;
    dmag = dneg ? (~den_i + CW'(1)) : den_i;
    spec = 1'b0;
    specv = '0;
    if (dmag == '0) begin
      spec = 1'b1;
      specv = nneg ? MINV : MAXV;
    end else if (nmag == '0) begin
      spec = 1'b1;
      specv = '0;
    end
  end

  // entry stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= {nmag, {FRAC_BITS{1'b0}}};
      r_q[0]   <= '0;
      dm_q[0]  <= dmag;
      neg_q[0] <= nneg ^ dneg;
      sp_q[0]  <= spec;
      spv_q[0] <= specv;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [CW:0] rr;
    logic [CW:0] rs;
    logic        ge;

    always_comb begin
      rr = {r_q[k], x_q[k][NW-1]};
      ge = (rr >= {1'b0, dm_q[k]});
      rs = ge ? (rr - {1'b0, dm_q[k]}) : rr;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+1]   <= {x_q[k][NW-2:0], ge};
        r_q[k+1]   <= rs[CW-1:0];
        dm_q[k+1]  <= dm_q[k];
        neg_q[k+1] <= neg_q[k];
        sp_q[k+1]  <= sp_q[k];
        spv_q[k+1] <= spv_q[k];
      end
    end
  end

  // saturate and apply the sign
  logic [NW-1:0] qf;
  logic [NW-1:0] qc;
  logic [CW-1:0] res;

  always_comb begin
    qf = x_q[NW];
    if (neg_q[NW]) begin
      qc  = (qf > CAP) ? CAP : qf;
      res = CW'(~qc + NW'(1));
    end else begin
      qc  = (qf > MAXQ) ? MAXQ : qf;
      res = qc[CW-1:0];
    end
    if (sp_q[NW]) begin
      res = spv_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= res;
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== design/rbsi_lane.sv =====
module rbsi_lane #(
  parameter int unsigned COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] origin_i,
  input  logic signed [COORD_WIDTH-1:0] heading_i,
  input  logic signed [COORD_WIDTH-1:0] low_i,
  input  logic signed [COORD_WIDTH-1:0] high_i,
  output logic signed [COORD_WIDTH-1:0] near_o,
  output logic signed [COORD_WIDTH-1:0] far_o
);
  import rbsi_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;

  logic signed [CW:0]   dist_lo;
  logic signed [CW:0]   dist_hi;
  logic signed [CW-1:0] t0;
  logic signed [CW-1:0] t1;
  logic signed [CW-1:0] near_q;
  logic signed [CW-1:0] far_q;

  // face distances at full precision
  assign dist_lo = (CW+1)'(low_i) - (CW+1)'(origin_i);
  assign dist_hi = (CW+1)'(high_i) - (CW+1)'(origin_i);

  rbsi_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_lo (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (dist_lo),
    .den_i (heading_i),
    .quo_o (t0)
  );

  rbsi_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_hi (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (dist_hi),
    .den_i (heading_i),
    .quo_o (t1)
  );

  // order the two slab parameters
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_q <= (t1 < t0) ? t1 : t0;
      far_q  <= (t1 < t0) ? t0 : t1;
    end
  end

  assign near_o = near_q;
  assign far_o  = far_q;

endmodule

// ===== design/rbsi_merge.sv =====
module rbsi_merge #(
  parameter int unsigned COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] near_i [rbsi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] far_i  [rbsi_pkg::NUM_AXES],
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] entry_o
);
  import rbsi_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};

  logic signed [CW-1:0] tmin;
  logic signed [CW-1:0] tmax;
  logic signed [CW-1:0] tmin_q;
  logic signed [CW-1:0] tmax_q;

  // largest near and smallest far over the lanes
  always_comb begin
    tmin = near_i[0];
    tmax = far_i[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (near_i[a] > tmin) tmin = near_i[a];
      if (far_i[a] < tmax) tmax = far_i[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tmin_q <= tmin;
      tmax_q <= tmax;
    end
  end

  // hit test and miss value
  assign hit_o   = (tmax_q >= tmin_q) && (tmax_q > 0);
  assign entry_o = hit_o ? tmin_q : MAXV;

endmodule

// ===== design/ray_box_slab_intersect.sv =====
// throughput: one item per cycle unless the output stalls; each axis lane has two dividers
// of one quotient bit per stage
// the whole pipeline holds while a result waits at the output register
// reset: asynchronous, active low; clears the valid pipeline, low faces to max, high to min
module ray_box_slab_intersect #(
  parameter int unsigned COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF,
  localparam int unsigned DATA_W = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int unsigned SH     = (COORD_WIDTH > 32) ? 3 : 2,
  localparam int unsigned ADDR_W = SH + 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ray_in_if.sink            ray_i,
  hit_out_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);
  import rbsi_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned NW  = CW + 1 + FRAC_BITS;
  localparam int unsigned LAT = NW + 4;
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] low_q  [NUM_AXES];
  logic signed [CW-1:0] high_q [NUM_AXES];

  // register file
  box_reg_e idx;
  logic     wr;

  assign idx    = box_reg_e'(paddr[ADDR_W-1:SH]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        low_q[a]  <= MAXV;
        high_q[a] <= MINV;
      end
    end else if (wr) begin
      unique case (idx)
        REG_LOW_X:  low_q[0]  <= pwdata[CW-1:0];
        REG_LOW_Y:  low_q[1]  <= pwdata[CW-1:0];
        REG_LOW_Z:  low_q[2]  <= pwdata[CW-1:0];
        REG_HIGH_X: high_q[0] <= pwdata[CW-1:0];
        REG_HIGH_Y: high_q[1] <= pwdata[CW-1:0];
        REG_HIGH_Z: high_q[2] <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOW_X:  prdata = DATA_W'(low_q[0]);
      REG_LOW_Y:  prdata = DATA_W'(low_q[1]);
      REG_LOW_Z:  prdata = DATA_W'(low_q[2]);
      REG_HIGH_X: prdata = DATA_W'(high_q[0]);
      REG_HIGH_Y: prdata = DATA_W'(high_q[1]);
      REG_HIGH_Z: prdata = DATA_W'(high_q[2]);
      default:    prdata = '0;
    endcase
  end

  // pipeline advances unless a result is held at the output
  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || res_o.ready;
  assign ray_i.ready = en;

  // per axis lanes
  logic signed [CW-1:0] org  [NUM_AXES];
  logic signed [CW-1:0] dir  [NUM_AXES];
  logic signed [CW-1:0] near [NUM_AXES];
  logic signed [CW-1:0] far  [NUM_AXES];

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.heading_x;
  assign dir[1] = ray_i.heading_y;
  assign dir[2] = ray_i.heading_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbsi_lane #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .origin_i  (org[a]),
      .heading_i (dir[a]),
      .low_i     (low_q[a]),
      .high_i    (high_q[a]),
      .near_o    (near[a]),
      .far_o     (far[a])
    );
  end

  logic                 hit;
  logic signed [CW-1:0] entry;

  rbsi_merge #(.COORD_WIDTH(CW)) u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .near_i  (near),
    .far_i   (far),
    .hit_o   (hit),
    .entry_o (entry)
  );

  // item valid tracking alongside the datapath
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LAT-2:0], ray_i.valid};
      out_valid_q <= vld_q[LAT-1];
    end
  end

  // output register
  logic                 hit_q;
  logic signed [CW-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit;
      entry_q <= entry;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.hit            = hit_q;
  assign res_o.entry_distance = entry_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rbsi_pkg::*;

  localparam int unsigned CW       = 32;
  localparam int unsigned FB       = 16;
  localparam int unsigned LATENCY  = CW + FB + 6;
  localparam int unsigned WD_LIMIT = 20000;
  localparam logic signed [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] QMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE  = 32'sd65536;

  typedef struct {
    logic signed [CW-1:0] org[3];
    logic signed [CW-1:0] dir[3];
  } ray_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] entry_dist;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ray_in_if  #(.W(CW)) ray_bus ();
  hit_out_if #(.W(CW)) res_bus ();

  ray_box_slab_intersect u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ray_i   (ray_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // box corners as the block should hold them
  logic signed [CW-1:0] box_lo[3];
  logic signed [CW-1:0] box_hi[3];

  hit_t pending_hits[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_request = 0;
  int   quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    ray_bus.valid     = 1'b0;
    ray_bus.origin_x  = '0;
    ray_bus.origin_y  = '0;
    ray_bus.origin_z  = '0;
    ray_bus.heading_x = '0;
    ray_bus.heading_y = '0;
    ray_bus.heading_z = '0;
    res_bus.ready     = 1'b0;
  end

  // slab quotient, exact division then saturation
  function automatic logic signed [CW-1:0] slab_quotient(logic signed [CW-1:0] face,
                                                         logic signed [CW-1:0] org,
                                                         logic signed [CW-1:0] dir);
    longint          span;
    longint unsigned nmag, dmag, quot;
    bit              nneg, dneg;
    span = longint'(face) - longint'(org);
    nneg = span < 0;
    nmag = nneg ? -span : span;
    dneg = dir < 0;
    dmag = dneg ? -longint'(dir) : longint'(dir);
    if (dmag == 0) return nneg ? QMIN : QMAX;
    if (nmag == 0) return '0;
    quot = (nmag << FB) / dmag;
    if (nneg != dneg) begin
      if (quot > 64'h8000_0000) quot = 64'h8000_0000;
      return CW'(-quot);
    end
    if (quot > 64'h7fff_ffff) quot = 64'h7fff_ffff;
    return CW'(quot);
  endfunction

  function automatic hit_t trace_ray(ray_t r);
    hit_t                 res;
    logic signed [CW-1:0] t0, t1, nearv, farv, t_entry, t_exit;
    for (int a = 0; a < 3; a++) begin
      t0 = slab_quotient(box_lo[a], r.org[a], r.dir[a]);
      t1 = slab_quotient(box_hi[a], r.org[a], r.dir[a]);
      nearv = (t1 < t0) ? t1 : t0;
      farv  = (t1 < t0) ? t0 : t1;
      if (a == 0 || nearv > t_entry) t_entry = nearv;
      if (a == 0 || farv < t_exit) t_exit = farv;
    end
    res.hit        = (t_exit >= t_entry) && (t_exit > 0);
    res.entry_dist = res.hit ? t_entry : QMAX;
    return res;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_request <= hold_request - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check; values seen at the falling edge hold through the next rising one
  always @(negedge clk_i) begin
    hit_t want;
    if (rst_ni) begin
      if ((ray_bus.valid && ray_bus.ready) || (res_bus.valid && res_bus.ready) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (res_bus.valid && res_bus.ready) begin
        if (pending_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result hit=%0b dist=%0d",
                                         res_bus.hit, res_bus.entry_distance);
        end else begin
          want = pending_hits.pop_front();
          if (want.hit !== res_bus.hit || want.entry_dist !== res_bus.entry_distance) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit=%0b dist=%0d, got hit=%0b dist=%0d",
                       want.hit, want.entry_dist, res_bus.hit, res_bus.entry_distance);
          end
        end
      end
      if (quiet_cycles >= WD_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // one ray, held until the block takes it
  task automatic send_ray(ray_t r);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      ray_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    ray_bus.valid     <= 1'b1;
    ray_bus.origin_x  <= r.org[0];
    ray_bus.origin_y  <= r.org[1];
    ray_bus.origin_z  <= r.org[2];
    ray_bus.heading_x <= r.dir[0];
    ray_bus.heading_y <= r.dir[1];
    ray_bus.heading_z <= r.dir[2];
    do begin
      @(negedge clk_i);
      taken = ray_bus.ready;
      @(posedge clk_i);
    end while (!taken);
    pending_hits.push_back(trace_ray(r));
  endtask

  task automatic drain();
    ray_bus.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 6) @(posedge clk_i);
  endtask

  // register write, only with the block drained
  task automatic write_box(box_reg_e idx, logic signed [CW-1:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx <= REG_LOW_Z) box_lo[idx] = val;
    else if (idx <= REG_HIGH_Z) box_hi[idx - REG_HIGH_X] = val;
  endtask

  task automatic set_box(logic signed [CW-1:0] lo[3], logic signed [CW-1:0] hi[3]);
    write_box(REG_LOW_X, lo[0]);
    write_box(REG_LOW_Y, lo[1]);
    write_box(REG_LOW_Z, lo[2]);
    write_box(REG_HIGH_X, hi[0]);
    write_box(REG_HIGH_Y, hi[1]);
    write_box(REG_HIGH_Z, hi[2]);
  endtask

  function automatic ray_t make_ray(logic signed [CW-1:0] ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    return r;
  endfunction

  // rays mostly aimed into the box, some reversed or with zero heading, with some noise items of any bit pattern
  function automatic ray_t random_ray();
    ray_t r;
    int   sel;
    logic signed [CW-1:0] target;
    sel = $urandom_range(99);
    for (int a = 0; a < 3; a++) begin
      if (sel < 15) begin
        r.org[a] = $urandom;
        r.dir[a] = $urandom;
      end else begin
        target = box_lo[a] + CW'($urandom_range(0, 255) * ((box_hi[a] - box_lo[a]) >>> 8));
        r.org[a] = $signed($urandom_range(0, 400 * 65536)) - 200 * 65536;
        r.dir[a] = (target - r.org[a]) >>> $urandom_range(0, 8);
        if (sel < 25) r.dir[a] = -r.dir[a];
        if ($urandom_range(19) == 0) r.dir[a] = '0;
      end
    end
    return r;
  endfunction

  task automatic random_box();
    logic signed [CW-1:0] lo[3], hi[3];
    for (int a = 0; a < 3; a++) begin
      lo[a] = $signed($urandom_range(0, 200 * 65536)) - 100 * 65536;
      hi[a] = lo[a] + $signed($urandom_range(65536, 40 * 65536));
    end
    set_box(lo, hi);
  endtask

  // the reset box has low faces at max and high faces at min; faces are ordered per axis, so rays can hit
  task automatic test_reset_box();
    send_ray(make_ray(0, 0, 0, ONE, ONE, ONE));
    send_ray(make_ray(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX));
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_directed();
    logic signed [CW-1:0] lo[3], hi[3];
    lo = '{-ONE, -ONE, -ONE};
    hi = '{ONE, ONE, ONE};
    set_box(lo, hi);
    send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0));
    send_ray(make_ray(-5 * ONE, 0, 0, -ONE, 0, 0));
    send_ray(make_ray(0, 0, 0, ONE, ONE, ONE));
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(5 * ONE, 0, 0, 0, ONE, 0));
    send_ray(make_ray(ONE, ONE, -ONE, -ONE, -ONE, ONE));
    send_ray(make_ray(-ONE, -ONE, -ONE, 0, 0, 0));
    send_ray(make_ray(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN));
    send_ray(make_ray(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX));
    send_ray(make_ray(QMIN, 0, 0, 1, 0, 0));
    send_ray(make_ray(QMAX, 0, 0, -1, 0, 0));
    send_ray(make_ray(-3 * ONE, -3 * ONE, 0, 1, 1, -1));
    send_ray(make_ray(0, 0, 2 * ONE, 0, 0, 1));
    // widest possible box
    lo = '{QMIN, QMIN, QMIN};
    hi = '{QMAX, QMAX, QMAX};
    set_box(lo, hi);
    send_ray(make_ray(0, 0, 0, ONE, -ONE, 1));
    send_ray(make_ray(QMAX, QMIN, 0, -1, 1, 0));
    send_ray(make_ray(QMIN, QMAX, QMAX, QMIN, QMAX, 0));
    // inverted box on one axis
    lo = '{ONE, -ONE, -ONE};
    hi = '{-ONE, ONE, ONE};
    set_box(lo, hi);
    send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    write_box(REG_SPARE0, 32'h1234_5678);
    send_ray(make_ray(0, -5 * ONE, 0, 0, ONE, 0));
    drain();
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 95 == 0) random_box();
      send_ray(random_ray());
    end
    drain();
  endtask

  // long receiver hold-off while rays keep coming
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_box();
    hold_request = 300;
    for (int i = 0; i < 120; i++) send_ray(random_ray());
    drain();
  endtask

  initial begin
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = QMAX;
      box_hi[a] = QMIN;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_box();
    test_directed();
    test_random(0, 0, 380);
    test_random(79, 0, 340);
    test_random(0, 79, 340);
    test_random(20, 20, 340);
    test_backpressure();
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== ray_box_slab_intersect.f =====
design/rbsi_pkg.sv
design/ray_in_if.sv
design/hit_out_if.sv
design/rbsi_div.sv
design/rbsi_lane.sv
design/rbsi_merge.sv
design/ray_box_slab_intersect.sv
bench/tb.sv
